// File: rtl/mts_pkg.sv
`default_nettype none
package mts_pkg;

	localparam int TOKEN_CHARS = 62;
	localparam int ADDR_W      = $clog2(TOKEN_CHARS);
	localparam int LEN_W       = $clog2(TOKEN_CHARS + 1);

	localparam logic [7:0] CH_LT = 8'h3C;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_LB = 8'h5B;
	localparam logic [7:0] CH_RB = 8'h5D;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	// Output byte sources.
	localparam int SEL_W = 4;
	localparam logic [SEL_W-1:0] SEL_IN  = 4'd0;
	localparam logic [SEL_W-1:0] SEL_RAM = 4'd1;
	localparam logic [SEL_W-1:0] SEL_ACC = 4'd2;
	localparam logic [SEL_W-1:0] SEL_SP  = 4'd3;
	localparam logic [SEL_W-1:0] SEL_LT  = 4'd4;
	localparam logic [SEL_W-1:0] SEL_GT  = 4'd5;
	localparam logic [SEL_W-1:0] SEL_LB  = 4'd6;
	localparam logic [SEL_W-1:0] SEL_RB  = 4'd7;
	localparam logic [SEL_W-1:0] SEL_NL  = 4'd8;

	// Tag actions.
	localparam int ACT_W = 3;
	localparam logic [ACT_W-1:0] ACT_NONE = 3'd0;
	localparam logic [ACT_W-1:0] ACT_WRAP = 3'd1;
	localparam logic [ACT_W-1:0] ACT_RF   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_RFL  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CA   = 3'd4;
	localparam logic [ACT_W-1:0] ACT_CG   = 3'd5;
	localparam logic [ACT_W-1:0] ACT_NL   = 3'd6;
	localparam logic [ACT_W-1:0] ACT_NL2  = 3'd7;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       start_of_text;
	} char_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} emit_t;

	typedef struct packed {
		logic             accept;
		logic             load_out;
		logic [SEL_W-1:0] out_sel;
		logic             out_last;
		logic             rd_en;
		logic             idx_init;
		logic             idx_inc;
		logic             ca_step;
	} cmd_t;

	typedef struct packed {
		logic             is_plain;
		logic             is_close;
		logic [ACT_W-1:0] action;
		logic             idx_lt_len;
		logic             ca_more;
		logic             out_free;
	} stat_t;

endpackage
`default_nettype wire

// File: rtl/markup_tag_stripper.sv
// Markup tag stripper: text bytes enter on the char channel, plain text leaves
// on the emit channel. Each channel moves a request when valid is high and
// stall is low at a rising clock edge.
// A byte outside a tag appears on the output in the cycle after it is taken, and
// such bytes flow at one per cycle unless the output stalls. Bytes inside a tag
// produce nothing and are likewise taken one per cycle. A closing '>' holds off
// the input while its results go out: a decode state, then one send state per
// constant byte; a wrapped body byte takes a read and a send state, a numeric
// character a read and a check state, as the tag buffer RAM read is registered.
// The last result caused by an input request carries last_of_run.
// Reset clears the open-tag flag, the buffer length and the output valid flag;
// the buffer RAM needs no clearing. A stall on the output holds the pending
// result and, through the shared output register, stalls the input as well.
`default_nettype none
module markup_tag_stripper (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           char_valid,
	output logic                char_stall,
	input  wire mts_pkg::char_t char_data,
	output logic                emit_valid,
	input  wire logic           emit_stall,
	output mts_pkg::emit_t      emit_data
);
	import mts_pkg::*;

	cmd_t  cmd;
	stat_t st;
	logic  ready;

	mts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(char_valid),
		.st        (st),
		.cmd       (cmd),
		.ready     (ready)
	);

	mts_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_data (char_data),
		.cmd       (cmd),
		.st        (st),
		.emit_stall(emit_stall),
		.emit_valid(emit_valid),
		.emit_data (emit_data)
	);

	assign char_stall = !ready;

endmodule
`default_nettype wire

// File: rtl/mts_ram.sv
`default_nettype none
module mts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// The read word holds until the next read.
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/mts_dp.sv
`default_nettype none
module mts_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mts_pkg::char_t char_data,
	input  wire mts_pkg::cmd_t  cmd,
	output mts_pkg::stat_t      st,
	input  wire logic          emit_stall,
	output logic               emit_valid,
	output mts_pkg::emit_t      emit_data
);
	import mts_pkg::*;

	logic             in_tag_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] idx_q;
	logic [7:0]       head0_q;
	logic [7:0]       head1_q;
	logic [7:0]       acc_q;
	logic             neg_q;
	logic             phase_q;
	logic             out_valid_q;
	emit_t            out_q;

	logic             tag_eff;
	logic [LEN_W-1:0] len_eff;
	logic             is_open;
	logic             is_close;
	logic             store;
	logic [7:0]       rdata;
	logic [7:0]       hd_a;
	logic [7:0]       hd_b;
	logic [ACT_W-1:0] action;
	logic             c_ws;
	logic             c_sign;
	logic             c_dig;
	logic             ca_more;
	logic [7:0]       acc_out;
	logic [7:0]       out_byte;

	// A new text starts with no open tag and an empty buffer.
	assign tag_eff  = char_data.start_of_text ? 1'b0 : in_tag_q;
	assign len_eff  = char_data.start_of_text ? '0 : len_q;
	assign is_open  = (char_data.in_byte == CH_LT);
	assign is_close = (char_data.in_byte == CH_GT);
	assign store    = cmd.accept && !is_open && !is_close && tag_eff &&
	                  (len_eff < LEN_W'(TOKEN_CHARS));

	mts_ram #(
		.WIDTH(8),
		.DEPTH(TOKEN_CHARS)
	) u_buf (
		.clk  (clk),
		.we   (store),
		.waddr(len_eff[ADDR_W-1:0]),
		.wdata(char_data.in_byte),
		.re   (cmd.rd_en),
		.raddr(idx_q[ADDR_W-1:0]),
		.rdata(rdata)
	);

	// Head positions beyond the stored length read as zero.
	assign hd_a = (len_q > LEN_W'(0)) ? head0_q : 8'h00;
	assign hd_b = (len_q > LEN_W'(1)) ? head1_q : 8'h00;

	always_comb begin
		action = ACT_NONE;
		if (hd_a == "W" && (hd_b == "G" || hd_b == "H" || hd_b == "T")) begin
			action = ACT_WRAP;
		end else if (hd_a == "R" && hd_b == "F") begin
			action = ACT_RF;
		end else if (hd_a == "R" && hd_b == "f") begin
			action = ACT_RFL;
		end else if (hd_a == "C") begin
			case (hd_b)
				"A":      action = ACT_CA;
				"G":      action = ACT_CG;
				"L", "N": action = ACT_NL;
				"M":      action = ACT_NL2;
				default:  action = ACT_NONE;
			endcase
		end
	end

	// Number scan: leading white space and one sign only before the first digit.
	assign c_ws   = (rdata == CH_SP) || (rdata >= 8'd9 && rdata <= 8'd13);
	assign c_sign = (rdata == CH_PLUS) || (rdata == CH_MINUS);
	assign c_dig  = (rdata >= CH_0) && (rdata <= CH_9);
	assign ca_more = phase_q ? c_dig : (c_ws || c_sign || c_dig);
	assign acc_out = neg_q ? 8'(8'd0 - acc_q) : acc_q;

	always_comb begin
		case (cmd.out_sel)
			SEL_IN:  out_byte = char_data.in_byte;
			SEL_RAM: out_byte = rdata;
			SEL_ACC: out_byte = acc_out;
			SEL_SP:  out_byte = CH_SP;
			SEL_LT:  out_byte = CH_LT;
			SEL_GT:  out_byte = CH_GT;
			SEL_LB:  out_byte = CH_LB;
			SEL_RB:  out_byte = CH_RB;
			SEL_NL:  out_byte = CH_NL;
			default: out_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tag_q    <= 1'b0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				if (is_open) begin
					in_tag_q <= 1'b1;
					len_q    <= '0;
				end else if (is_close) begin
					in_tag_q <= 1'b0;
					len_q    <= len_eff;
				end else begin
					in_tag_q <= tag_eff;
					if (store) begin
						len_q <= LEN_W'(len_eff + LEN_W'(1));
					end else begin
						len_q <= len_eff;
					end
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!emit_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store && len_eff == LEN_W'(0)) begin
			head0_q <= char_data.in_byte;
		end
		if (store && len_eff == LEN_W'(1)) begin
			head1_q <= char_data.in_byte;
		end
		if (cmd.idx_init) begin
			idx_q   <= LEN_W'(2);
			acc_q   <= 8'h00;
			neg_q   <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (cmd.idx_inc) begin
				idx_q <= LEN_W'(idx_q + LEN_W'(1));
			end
			if (cmd.ca_step) begin
				if (c_dig) begin
					phase_q <= 1'b1;
					acc_q   <= 8'(acc_q * 8'd10 + 8'(rdata - CH_0));
				end else if (!phase_q && c_sign) begin
					phase_q <= 1'b1;
					neg_q   <= (rdata == CH_MINUS);
				end
			end
		end
		if (cmd.load_out) begin
			out_q.out_byte    <= out_byte;
			out_q.last_of_run <= cmd.out_last;
		end
	end

	assign st.is_plain   = !is_open && !is_close && !tag_eff;
	assign st.is_close   = is_close;
	assign st.action     = action;
	assign st.idx_lt_len = (idx_q < len_q);
	assign st.ca_more    = ca_more;
	assign st.out_free   = !out_valid_q || !emit_stall;

	assign emit_valid = out_valid_q;
	assign emit_data  = out_q;

endmodule
`default_nettype wire

// File: rtl/mts_ctrl.sv
`default_nettype none
module mts_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           char_valid,
	input  wire mts_pkg::stat_t st,
	output mts_pkg::cmd_t       cmd,
	output logic                ready
);
	import mts_pkg::*;

	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_DEC     = 5'd1;
	localparam logic [4:0] ST_W_SP    = 5'd2;
	localparam logic [4:0] ST_W_LT    = 5'd3;
	localparam logic [4:0] ST_W_RD    = 5'd4;
	localparam logic [4:0] ST_W_BY    = 5'd5;
	localparam logic [4:0] ST_W_GT    = 5'd6;
	localparam logic [4:0] ST_SP_LAST = 5'd7;
	localparam logic [4:0] ST_RF_SP   = 5'd8;
	localparam logic [4:0] ST_LB_LAST = 5'd9;
	localparam logic [4:0] ST_RB      = 5'd10;
	localparam logic [4:0] ST_GT_LAST = 5'd11;
	localparam logic [4:0] ST_NL      = 5'd12;
	localparam logic [4:0] ST_NL_LAST = 5'd13;
	localparam logic [4:0] ST_CA_RD   = 5'd14;
	localparam logic [4:0] ST_CA_CHK  = 5'd15;
	localparam logic [4:0] ST_CA_EMIT = 5'd16;

	logic [4:0]       state_q;
	logic [4:0]       nxt;
	logic             em;
	logic [SEL_W-1:0] em_sel;
	logic             em_last;
	logic [4:0]       em_nxt;

	always_comb begin
		nxt     = state_q;
		cmd     = '0;
		ready   = 1'b0;
		em      = 1'b0;
		em_sel  = SEL_SP;
		em_last = 1'b0;
		em_nxt  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				ready = st.out_free;
				if (char_valid && st.out_free) begin
					cmd.accept = 1'b1;
					if (st.is_plain) begin
						cmd.load_out = 1'b1;
						cmd.out_sel  = SEL_IN;
						cmd.out_last = 1'b1;
					end
					if (st.is_close) begin
						nxt = ST_DEC;
					end
				end
			end
			ST_DEC: begin
				cmd.idx_init = 1'b1;
				unique case (st.action)
					ACT_WRAP: nxt = ST_W_SP;
					ACT_RF:   nxt = ST_RF_SP;
					ACT_RFL:  nxt = ST_RB;
					ACT_CA:   nxt = ST_CA_RD;
					ACT_CG:   nxt = ST_GT_LAST;
					ACT_NL:   nxt = ST_NL_LAST;
					ACT_NL2:  nxt = ST_NL;
					default:  nxt = ST_IDLE;
				endcase
			end
			ST_W_SP: begin
				em = 1'b1; em_sel = SEL_SP; em_nxt = ST_W_LT;
			end
			ST_W_LT: begin
				em = 1'b1; em_sel = SEL_LT; em_nxt = ST_W_RD;
			end
			ST_W_RD: begin
				if (st.idx_lt_len) begin
					cmd.rd_en = 1'b1;
					nxt       = ST_W_BY;
				end else begin
					nxt = ST_W_GT;
				end
			end
			ST_W_BY: begin
				em = 1'b1; em_sel = SEL_RAM; em_nxt = ST_W_RD;
			end
			ST_W_GT: begin
				em = 1'b1; em_sel = SEL_GT; em_nxt = ST_SP_LAST;
			end
			ST_SP_LAST: begin
				em = 1'b1; em_sel = SEL_SP; em_last = 1'b1; em_nxt = ST_IDLE;
			end
			ST_RF_SP: begin
				em = 1'b1; em_sel = SEL_SP; em_nxt = ST_LB_LAST;
			end
			ST_LB_LAST: begin
				em = 1'b1; em_sel = SEL_LB; em_last = 1'b1; em_nxt = ST_IDLE;
			end
			ST_RB: begin
				em = 1'b1; em_sel = SEL_RB; em_nxt = ST_SP_LAST;
			end
			ST_GT_LAST: begin
				em = 1'b1; em_sel = SEL_GT; em_last = 1'b1; em_nxt = ST_IDLE;
			end
			ST_NL: begin
				em = 1'b1; em_sel = SEL_NL; em_nxt = ST_NL_LAST;
			end
			ST_NL_LAST: begin
				em = 1'b1; em_sel = SEL_NL; em_last = 1'b1; em_nxt = ST_IDLE;
			end
			ST_CA_RD: begin
				if (st.idx_lt_len) begin
					cmd.rd_en = 1'b1;
					nxt       = ST_CA_CHK;
				end else begin
					nxt = ST_CA_EMIT;
				end
			end
			ST_CA_CHK: begin
				cmd.ca_step = 1'b1;
				if (st.ca_more) begin
					cmd.idx_inc = 1'b1;
					nxt         = ST_CA_RD;
				end else begin
					nxt = ST_CA_EMIT;
				end
			end
			ST_CA_EMIT: begin
				em = 1'b1; em_sel = SEL_ACC; em_last = 1'b1; em_nxt = ST_IDLE;
			end
			default: begin
				nxt = ST_IDLE;
			end
		endcase
		if (em && st.out_free) begin
			cmd.load_out = 1'b1;
			cmd.out_sel  = em_sel;
			cmd.out_last = em_last;
			nxt          = em_nxt;
			// Each body byte sent moves the read pointer on.
			if (state_q == ST_W_BY) begin
				cmd.idx_inc = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= nxt;
		end
	end

endmodule
`default_nettype wire

// File: rtl/mts_checker.sv
`default_nettype none
module mts_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           char_valid,
	input wire logic           char_stall,
	input wire mts_pkg::char_t char_data,
	input wire logic           emit_valid,
	input wire logic           emit_stall,
	input wire mts_pkg::emit_t emit_data
);
	import mts_pkg::*;

	// A held result keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		emit_valid && emit_stall |=> emit_valid && $stable(emit_data))
		else $error("stalled result changed");

	// The input cannot get past a blocked output register.
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		emit_valid && emit_stall |-> char_stall)
		else $error("input taken while output blocked");

	// A closing bracket is followed by the decode cycle.
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_stall && char_data.in_byte == CH_GT |=> char_stall)
		else $error("input taken during tag decode");

	// An opening bracket yields no result.
	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_stall && char_data.in_byte == CH_LT |=> !emit_valid)
		else $error("result produced by tag open");

endmodule

bind markup_tag_stripper mts_checker u_chk (.*);
`default_nettype wire
